### rtl/tcp_active_open_close_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the open/close sequencer modules.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef TCP_ACTIVE_OPEN_CLOSE_SEQUENCER_MACROS_SVH
`define TCP_ACTIVE_OPEN_CLOSE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TAOCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TAOCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/taocs_pkg.sv
// ----------------------------------------------------------------------------
// taocs_pkg
// Shared types, command codes, result kinds and TCP state codes of the
// active open/close sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package taocs_pkg;

    // Field widths.
    localparam int unsigned SESS_W  = 10;
    localparam int unsigned IP_W    = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned STATE_W = 4;

    // Depth of the queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_OPEN_REQ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PORT_REPLY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_REPLY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RX_STATUS    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TIMER_STATUS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLOSE        = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STATE_REPLY  = 3'd6;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PORT_REQ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP_REQ = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN_REPLY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVENT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATE_QRY  = 3'd4;

    // Event types.
    localparam logic EVT_SYN = 1'b0;
    localparam logic EVT_FIN = 1'b1;

    // TCP session states used by the sequencer.
    localparam logic [STATE_W-1:0] ST_SYN_SENT    = 4'd1;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED = 4'd3;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_1  = 4'd4;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_2  = 4'd5;

    // Work orders passed from the front to the back.
    typedef enum logic [2:0] {
        OP_PORT_REQ,
        OP_LOOKUP_REQ,
        OP_SYN,
        OP_OPEN_REPLY,
        OP_QUERY_READ,
        OP_WRITE_STATE,
        OP_CLOSE_FIN
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SESS_W-1:0]  session;
        logic [IP_W-1:0]    local_ip;
        logic [PORT_W-1:0]  local_port;
        logic [IP_W-1:0]    remote_ip;
        logic [PORT_W-1:0]  remote_port;
        logic               success;
        logic [STATE_W-1:0] state;
    } work_rec_t;

    // Queue status seen by the back.
    typedef struct packed {
        logic      valid;
        work_rec_t rec;
    } q_head_t;

endpackage

`default_nettype wire

### rtl/taocs_front.sv
// ----------------------------------------------------------------------------
// taocs_front
// Accepts input transactions, tracks the open/close handshake mode and
// turns each transaction into at most one work record for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_active_open_close_sequencer_macros.svh"

module taocs_front
    import taocs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration
    input  wire logic               cfg_valid,
    input  wire logic [IP_W-1:0]    cfg_data,
    // Input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [IP_W-1:0]    remote_ip,
    input  wire logic [PORT_W-1:0]  remote_port,
    input  wire logic [PORT_W-1:0]  free_port,
    input  wire logic               lookup_hit,
    input  wire logic [SESS_W-1:0]  session_in,
    input  wire logic               success_in,
    input  wire logic [STATE_W-1:0] state_in,
    // Queue push side
    input  wire logic               q_full,
    output logic                    push_valid,
    output work_rec_t               push_rec
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT_PORT,
        MODE_WAIT_STATE
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [IP_W-1:0]    local_ip_reg;
    logic [IP_W-1:0]    pend_ip_reg, pend_ip_next;
    logic [PORT_W-1:0]  pend_port_reg, pend_port_next;
    logic [SESS_W-1:0]  close_sess_reg, close_sess_next;
    logic               accept;
    logic               emit;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && emit;

    // Classify the transaction against the current mode.
    always_comb
    begin
        mode_next       = mode_reg;
        pend_ip_next    = pend_ip_reg;
        pend_port_next  = pend_port_reg;
        close_sess_next = close_sess_reg;
        emit            = 1'b0;
        push_rec        = '0;
        push_rec.op     = OP_PORT_REQ;

        unique case (mode_reg)
            MODE_WAIT_PORT:
            begin
                if (cmd == CMD_PORT_REPLY)
                begin
                    emit                 = 1'b1;
                    push_rec.op          = OP_LOOKUP_REQ;
                    push_rec.local_ip    = local_ip_reg;
                    push_rec.local_port  = {free_port[7:0], free_port[15:8]};
                    push_rec.remote_ip   = pend_ip_reg;
                    push_rec.remote_port = pend_port_reg;
                    mode_next            = MODE_IDLE;
                end
            end
            MODE_WAIT_STATE:
            begin
                if (cmd == CMD_STATE_REPLY)
                begin
                    emit             = 1'b1;
                    push_rec.session = close_sess_reg;
                    if (state_in inside {ST_ESTABLISHED, ST_FIN_WAIT_1, ST_FIN_WAIT_2})
                    begin
                        push_rec.op    = OP_CLOSE_FIN;
                        push_rec.state = ST_FIN_WAIT_1;
                    end
                    else
                    begin
                        push_rec.op    = OP_WRITE_STATE;
                        push_rec.state = state_in;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                unique case (cmd) inside
                    CMD_OPEN_REQ:
                    begin
                        emit           = 1'b1;
                        push_rec.op    = OP_PORT_REQ;
                        pend_ip_next   = remote_ip;
                        pend_port_next = remote_port;
                        mode_next      = MODE_WAIT_PORT;
                    end
                    CMD_LOOKUP_REPLY:
                    begin
                        emit = 1'b1;
                        if (lookup_hit)
                        begin
                            push_rec.op      = OP_SYN;
                            push_rec.session = session_in;
                            push_rec.state   = ST_SYN_SENT;
                        end
                        else
                        begin
                            // Failed open: reply for session 0 without success.
                            push_rec.op = OP_OPEN_REPLY;
                        end
                    end
                    CMD_RX_STATUS, CMD_TIMER_STATUS:
                    begin
                        emit             = 1'b1;
                        push_rec.op      = OP_OPEN_REPLY;
                        push_rec.session = session_in;
                        push_rec.success = success_in;
                    end
                    CMD_CLOSE:
                    begin
                        emit             = 1'b1;
                        push_rec.op      = OP_QUERY_READ;
                        push_rec.session = session_in;
                        close_sess_next  = session_in;
                        mode_next        = MODE_WAIT_STATE;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Mode and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            local_ip_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
            end
            if (cfg_valid)
            begin
                local_ip_reg <= cfg_data;
            end
        end
    end

    // Pending open and close context.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_ip_reg    <= pend_ip_next;
            pend_port_reg  <= pend_port_next;
            close_sess_reg <= close_sess_next;
        end
    end

    // While waiting for a port reply only a lookup request may leave the front.
    `TAOCS_ASSERT_NOW(a_front_wait_port, push_valid && (mode_reg == MODE_WAIT_PORT),
        push_rec.op == OP_LOOKUP_REQ, "front: wrong record while waiting for port")
    // An accepted close always moves to waiting for the state reply.
    `TAOCS_ASSERT_NEXT(a_front_close, accept && (mode_reg == MODE_IDLE) && (cmd == CMD_CLOSE),
        mode_reg == MODE_WAIT_STATE, "front: close did not enter state wait")

endmodule

`default_nettype wire

### rtl/taocs_queue.sv
// ----------------------------------------------------------------------------
// taocs_queue
// Short first-in first-out queue of work records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_active_open_close_sequencer_macros.svh"

module taocs_queue
    import taocs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  wire work_rec_t push_rec,
    output logic           full,
    input  wire logic      pop,
    output q_head_t        head
);

    work_rec_t         mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.rec   = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_valid && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push_valid)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    `TAOCS_ASSERT_NOW(a_q_no_overflow, push_valid, !full || pop, "queue: push while full")
    `TAOCS_ASSERT_NOW(a_q_no_underflow, pop, head.valid, "queue: pop while empty")

endmodule

`default_nettype wire

### rtl/taocs_back.sv
// ----------------------------------------------------------------------------
// taocs_back
// Expands each work record into one or two result transactions and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_active_open_close_sequencer_macros.svh"

module taocs_back
    import taocs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire q_head_t             head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [KIND_W-1:0]        out_kind,
    output logic [SESS_W-1:0]        out_session,
    output logic [IP_W-1:0]          out_local_ip,
    output logic [PORT_W-1:0]        out_local_port,
    output logic [IP_W-1:0]          out_remote_ip,
    output logic [PORT_W-1:0]        out_remote_port,
    output logic                     out_event,
    output logic                     out_query_write,
    output logic [STATE_W-1:0]       out_state,
    output logic                     out_open_success,
    output logic                     out_last
);

    logic                 phase_reg;
    logic                 valid_reg;
    logic                 load;
    logic [KIND_W-1:0]    kind_c;
    logic [SESS_W-1:0]    sess_c;
    logic [IP_W-1:0]      lip_c, rip_c;
    logic [PORT_W-1:0]    lport_c, rport_c;
    logic                 event_c, qwr_c, succ_c, last_c;
    logic [STATE_W-1:0]   state_c;

    logic [KIND_W-1:0]    kind_reg;
    logic [SESS_W-1:0]    sess_reg;
    logic [IP_W-1:0]      lip_reg, rip_reg;
    logic [PORT_W-1:0]    lport_reg, rport_reg;
    logic                 event_reg, qwr_reg, succ_reg, last_reg;
    logic [STATE_W-1:0]   state_reg;

    assign load = head.valid && (!valid_reg || out_ready);
    assign pop  = load && last_c;

    // Build the result for the head record and the current phase.
    always_comb
    begin
        kind_c  = KIND_PORT_REQ;
        sess_c  = '0;
        lip_c   = '0;
        lport_c = '0;
        rip_c   = '0;
        rport_c = '0;
        event_c = EVT_SYN;
        qwr_c   = 1'b0;
        state_c = '0;
        succ_c  = 1'b0;
        last_c  = 1'b1;

        unique case (head.rec.op)
            OP_PORT_REQ:
            begin
                kind_c = KIND_PORT_REQ;
            end
            OP_LOOKUP_REQ:
            begin
                kind_c  = KIND_LOOKUP_REQ;
                lip_c   = head.rec.local_ip;
                lport_c = head.rec.local_port;
                rip_c   = head.rec.remote_ip;
                rport_c = head.rec.remote_port;
            end
            OP_SYN:
            begin
                sess_c = head.rec.session;
                if (!phase_reg)
                begin
                    kind_c  = KIND_EVENT;
                    event_c = EVT_SYN;
                    last_c  = 1'b0;
                end
                else
                begin
                    kind_c  = KIND_STATE_QRY;
                    qwr_c   = 1'b1;
                    state_c = head.rec.state;
                end
            end
            OP_OPEN_REPLY:
            begin
                kind_c = KIND_OPEN_REPLY;
                sess_c = head.rec.session;
                succ_c = head.rec.success;
            end
            OP_QUERY_READ:
            begin
                kind_c = KIND_STATE_QRY;
                sess_c = head.rec.session;
            end
            OP_WRITE_STATE:
            begin
                kind_c  = KIND_STATE_QRY;
                sess_c  = head.rec.session;
                qwr_c   = 1'b1;
                state_c = head.rec.state;
            end
            OP_CLOSE_FIN:
            begin
                sess_c = head.rec.session;
                if (!phase_reg)
                begin
                    kind_c  = KIND_STATE_QRY;
                    qwr_c   = 1'b1;
                    state_c = head.rec.state;
                    last_c  = 1'b0;
                end
                else
                begin
                    kind_c  = KIND_EVENT;
                    event_c = EVT_FIN;
                end
            end
            default:
            begin
                last_c = 1'b1;
            end
        endcase
    end

    // Output valid and expansion phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= !last_c;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_c;
            sess_reg  <= sess_c;
            lip_reg   <= lip_c;
            lport_reg <= lport_c;
            rip_reg   <= rip_c;
            rport_reg <= rport_c;
            event_reg <= event_c;
            qwr_reg   <= qwr_c;
            state_reg <= state_c;
            succ_reg  <= succ_c;
            last_reg  <= last_c;
        end
    end

    assign out_valid        = valid_reg;
    assign out_kind         = kind_reg;
    assign out_session      = sess_reg;
    assign out_local_ip     = lip_reg;
    assign out_local_port   = lport_reg;
    assign out_remote_ip    = rip_reg;
    assign out_remote_port  = rport_reg;
    assign out_event        = event_reg;
    assign out_query_write  = qwr_reg;
    assign out_state        = state_reg;
    assign out_open_success = succ_reg;
    assign out_last         = last_reg;

    // The record stays at the head while its second result is pending.
    `TAOCS_ASSERT_NOW(a_back_head_held, phase_reg, head.valid,
        "back: head lost during two-result expansion")
    // A taken first result of a pair is followed at once by the second.
    `TAOCS_ASSERT_NEXT(a_back_pair, out_valid && out_ready && !out_last,
        out_valid && out_last, "back: second result of a pair missing")

endmodule

`default_nettype wire

### rtl/tcp_active_open_close_sequencer.sv
// The first result of an input transaction passes through the work queue and then the output
// register before it can be taken.
// Throughput: one input transaction per cycle unless the queue is full; the output register
// drains one result per cycle while out_ready is high, each SYN or FIN giving two results.
// A two-entry queue lets the front keep accepting while the back is stalled by the consumer.
// Reset (rst_n low, asynchronous): mode idle, queue and output empty, local IP address zero.
// ----------------------------------------------------------------------------
// tcp_active_open_close_sequencer
// Top level: front classifier, work queue and result expander for active
// TCP open and close sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_active_open_close_sequencer
    import taocs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IP_W-1:0]    cfg_data,
    // Input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [IP_W-1:0]    remote_ip,
    input  wire logic [PORT_W-1:0]  remote_port,
    input  wire logic [PORT_W-1:0]  free_port,
    input  wire logic               lookup_hit,
    input  wire logic [SESS_W-1:0]  session_in,
    input  wire logic               success_in,
    input  wire logic [STATE_W-1:0] state_in,
    // Output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [KIND_W-1:0]       out_kind,
    output logic [SESS_W-1:0]       out_session,
    output logic [IP_W-1:0]         out_local_ip,
    output logic [PORT_W-1:0]       out_local_port,
    output logic [IP_W-1:0]         out_remote_ip,
    output logic [PORT_W-1:0]       out_remote_port,
    output logic                    out_event,
    output logic                    out_query_write,
    output logic [STATE_W-1:0]      out_state,
    output logic                    out_open_success,
    output logic                    out_last
);

    logic      q_full;
    logic      push_valid;
    work_rec_t push_rec;
    logic      pop;
    q_head_t   head;

    // The register write is always taken.
    assign cfg_ready = 1'b1;

    // Front: accepts and classifies input transactions.
    taocs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .remote_ip   (remote_ip),
        .remote_port (remote_port),
        .free_port   (free_port),
        .lookup_hit  (lookup_hit),
        .session_in  (session_in),
        .success_in  (success_in),
        .state_in    (state_in),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_rec    (push_rec)
    );

    // Work queue between the two halves.
    taocs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    // Back: expands records into result transactions.
    taocs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_kind         (out_kind),
        .out_session      (out_session),
        .out_local_ip     (out_local_ip),
        .out_local_port   (out_local_port),
        .out_remote_ip    (out_remote_ip),
        .out_remote_port  (out_remote_port),
        .out_event        (out_event),
        .out_query_write  (out_query_write),
        .out_state        (out_state),
        .out_open_success (out_open_success),
        .out_last         (out_last)
    );

endmodule

`default_nettype wire

### tb/seq_result_checker.sv
// ----------------------------------------------------------------------------
// seq_result_checker
// Watches the configuration, input and output channels of the active
// open/close sequencer. It keeps its own copy of the sequencer state, works
// out the results of every accepted input transaction and compares each
// output transaction, field by field, with the oldest result still expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_result_checker
    import taocs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration channel
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [IP_W-1:0]    cfg_data,
    // Input channel
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [IP_W-1:0]    remote_ip,
    input  wire logic [PORT_W-1:0]  remote_port,
    input  wire logic [PORT_W-1:0]  free_port,
    input  wire logic               lookup_hit,
    input  wire logic [SESS_W-1:0]  session_in,
    input  wire logic               success_in,
    input  wire logic [STATE_W-1:0] state_in,
    // Output channel
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [KIND_W-1:0]  out_kind,
    input  wire logic [SESS_W-1:0]  out_session,
    input  wire logic [IP_W-1:0]    out_local_ip,
    input  wire logic [PORT_W-1:0]  out_local_port,
    input  wire logic [IP_W-1:0]    out_remote_ip,
    input  wire logic [PORT_W-1:0]  out_remote_port,
    input  wire logic               out_event,
    input  wire logic               out_query_write,
    input  wire logic [STATE_W-1:0] out_state,
    input  wire logic               out_open_success,
    input  wire logic               out_last,
    // Status towards the testbench top
    output int unsigned             mismatch_count,
    output int unsigned             pending_results,
    output int unsigned             items_seen,
    output int unsigned             items_with_results,
    output int unsigned             results_checked
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AWAIT_PORT,
        MODE_AWAIT_STATE
    } seq_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SESS_W-1:0]  session;
        logic [IP_W-1:0]    local_ip;
        logic [PORT_W-1:0]  local_port;
        logic [IP_W-1:0]    remote_ip;
        logic [PORT_W-1:0]  remote_port;
        logic               evt;
        logic               query_write;
        logic [STATE_W-1:0] state;
        logic               open_success;
        logic               last;
    } seq_result_t;

    // Shadow copy of the sequencer state and its register.
    seq_mode_t         mode;
    logic [IP_W-1:0]   cfg_local_ip;
    logic [IP_W-1:0]   held_remote_ip;
    logic [PORT_W-1:0] held_remote_port;
    logic [SESS_W-1:0] close_session;

    seq_result_t expected_results [$];

    int unsigned fails;
    int unsigned n_items;
    int unsigned n_active;
    int unsigned n_results;

    function automatic seq_result_t blank_result(input logic [KIND_W-1:0] kind);
        seq_result_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

    // Works out the results of one input transaction and moves the shadow state on.
    task automatic predict_sequencer_results(
        input logic [CMD_W-1:0]   c,
        input logic [IP_W-1:0]    rip,
        input logic [PORT_W-1:0]  rport,
        input logic [PORT_W-1:0]  fport,
        input logic               hit,
        input logic [SESS_W-1:0]  sess,
        input logic               succ,
        input logic [STATE_W-1:0] st
    );
        seq_result_t res [2];
        int          n;
        int          i;
        n = 0;
        case (mode)
            MODE_AWAIT_PORT:
            begin
                // Only the port reply is taken; anything else is dropped.
                if (c == CMD_PORT_REPLY)
                begin
                    res[0]             = blank_result(KIND_LOOKUP_REQ);
                    res[0].local_ip    = cfg_local_ip;
                    res[0].local_port  = {fport[7:0], fport[15:8]};
                    res[0].remote_ip   = held_remote_ip;
                    res[0].remote_port = held_remote_port;
                    n                  = 1;
                    mode               = MODE_IDLE;
                end
            end
            MODE_AWAIT_STATE:
            begin
                if (c == CMD_STATE_REPLY)
                begin
                    res[0]             = blank_result(KIND_STATE_QRY);
                    res[0].session     = close_session;
                    res[0].query_write = 1'b1;
                    if (st == ST_ESTABLISHED || st == ST_FIN_WAIT_1 || st == ST_FIN_WAIT_2)
                    begin
                        res[0].state   = ST_FIN_WAIT_1;
                        res[1]         = blank_result(KIND_EVENT);
                        res[1].session = close_session;
                        res[1].evt     = EVT_FIN;
                        n              = 2;
                    end
                    else
                    begin
                        // Same state written back only to release the lock.
                        res[0].state = st;
                        n            = 1;
                    end
                    mode = MODE_IDLE;
                end
            end
            default:
            begin
                // Idle: replies without a request and unknown commands are dropped.
                case (c)
                    CMD_OPEN_REQ:
                    begin
                        held_remote_ip   = rip;
                        held_remote_port = rport;
                        res[0]           = blank_result(KIND_PORT_REQ);
                        n                = 1;
                        mode             = MODE_AWAIT_PORT;
                    end
                    CMD_LOOKUP_REPLY:
                    begin
                        if (hit)
                        begin
                            res[0]             = blank_result(KIND_EVENT);
                            res[0].session     = sess;
                            res[0].evt         = EVT_SYN;
                            res[1]             = blank_result(KIND_STATE_QRY);
                            res[1].session     = sess;
                            res[1].query_write = 1'b1;
                            res[1].state       = ST_SYN_SENT;
                            n                  = 2;
                        end
                        else
                        begin
                            // Failed open is reported against session zero.
                            res[0] = blank_result(KIND_OPEN_REPLY);
                            n      = 1;
                        end
                    end
                    CMD_RX_STATUS, CMD_TIMER_STATUS:
                    begin
                        res[0]              = blank_result(KIND_OPEN_REPLY);
                        res[0].session      = sess;
                        res[0].open_success = succ;
                        n                   = 1;
                    end
                    CMD_CLOSE:
                    begin
                        close_session  = sess;
                        res[0]         = blank_result(KIND_STATE_QRY);
                        res[0].session = sess;
                        n              = 1;
                        mode           = MODE_AWAIT_STATE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        if (n > 0)
        begin
            res[n-1].last = 1'b1;
            n_active++;
        end
        for (i = 0; i < n; i++)
            expected_results.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fails++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Compares one output transaction with the oldest expected result.
    task automatic check_result();
        seq_result_t want;
        if (expected_results.size() == 0)
        begin
            fails++;
            $error("Result of kind %0d arrived with no result expected", out_kind);
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("out_kind", want.kind, out_kind);
            check_field("out_session", want.session, out_session);
            check_field("out_local_ip", want.local_ip, out_local_ip);
            check_field("out_local_port", want.local_port, out_local_port);
            check_field("out_remote_ip", want.remote_ip, out_remote_ip);
            check_field("out_remote_port", want.remote_port, out_remote_port);
            check_field("out_event", want.evt, out_event);
            check_field("out_query_write", want.query_write, out_query_write);
            check_field("out_state", want.state, out_state);
            check_field("out_open_success", want.open_success, out_open_success);
            check_field("out_last", want.last, out_last);
        end
        n_results++;
    endtask

    // Channel monitor: compare outputs, track the register, predict inputs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode             = MODE_IDLE;
            cfg_local_ip     = '0;
            held_remote_ip   = '0;
            held_remote_port = '0;
            close_session    = '0;
            expected_results.delete();
            fails            = 0;
            n_items          = 0;
            n_active         = 0;
            n_results        = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                cfg_local_ip = cfg_data;
            if (in_valid && in_ready)
            begin
                n_items++;
                predict_sequencer_results(cmd, remote_ip, remote_port, free_port,
                                          lookup_hit, session_in, success_in, state_in);
            end
        end
        mismatch_count     <= fails;
        pending_results    <= expected_results.size();
        items_seen         <= n_items;
        items_with_results <= n_active;
        results_checked    <= n_results;
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the active TCP open/close sequencer. A short directed
// run covers field extremes, every command and the dropped-item cases, then
// random open, close and status sequences with noise run under four idling
// mixes and four local address settings. Checking is left to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import taocs_pkg::*;

    // Command code with no meaning to the sequencer.
    localparam logic [CMD_W-1:0]   CMD_UNUSED   = 3'd7;
    localparam logic [STATE_W-1:0] ST_CLOSED    = 4'd0;
    localparam logic [STATE_W-1:0] ST_UNDEFINED = 4'd15;

    localparam int unsigned PHASE_ITEMS    = 275;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned NUM_PHASES     = 4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IP_W-1:0]    remote_ip;
        logic [PORT_W-1:0]  remote_port;
        logic [PORT_W-1:0]  free_port;
        logic               lookup_hit;
        logic [SESS_W-1:0]  session;
        logic               success;
        logic [STATE_W-1:0] state;
    } seq_item_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IP_W-1:0]    cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd;
    logic [IP_W-1:0]    remote_ip;
    logic [PORT_W-1:0]  remote_port;
    logic [PORT_W-1:0]  free_port;
    logic               lookup_hit;
    logic [SESS_W-1:0]  session_in;
    logic               success_in;
    logic [STATE_W-1:0] state_in;
    logic               out_valid;
    logic               out_ready;
    logic [KIND_W-1:0]  out_kind;
    logic [SESS_W-1:0]  out_session;
    logic [IP_W-1:0]    out_local_ip;
    logic [PORT_W-1:0]  out_local_port;
    logic [IP_W-1:0]    out_remote_ip;
    logic [PORT_W-1:0]  out_remote_port;
    logic               out_event;
    logic               out_query_write;
    logic [STATE_W-1:0] out_state;
    logic               out_open_success;
    logic               out_last;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned items_seen;
    int unsigned items_with_results;
    int unsigned results_checked;

    // Idling controls for the sender and the receiver.
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          hold_request;
    int unsigned cfg_writes;

    tcp_active_open_close_sequencer i_dut (.*);

    seq_result_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic seq_item_t random_item(input logic [CMD_W-1:0] c);
        seq_item_t it;
        it.cmd         = c;
        it.remote_ip   = $urandom;
        it.remote_port = PORT_W'($urandom);
        it.free_port   = PORT_W'($urandom);
        it.lookup_hit  = 1'($urandom);
        it.session     = SESS_W'($urandom);
        it.success     = 1'($urandom);
        it.state       = STATE_W'($urandom);
        return it;
    endfunction

    // Offers one input transaction, after an optional gap, and waits for its acceptance.
    task automatic send_item(input seq_item_t it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= it.cmd;
        remote_ip   <= it.remote_ip;
        remote_port <= it.remote_port;
        free_port   <= it.free_port;
        lookup_hit  <= it.lookup_hit;
        session_in  <= it.session;
        success_in  <= it.success;
        state_in    <= it.state;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_open(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
        seq_item_t it;
        it             = random_item(CMD_OPEN_REQ);
        it.remote_ip   = ip;
        it.remote_port = port;
        send_item(it);
    endtask

    task automatic send_port_reply(input logic [PORT_W-1:0] port);
        seq_item_t it;
        it           = random_item(CMD_PORT_REPLY);
        it.free_port = port;
        send_item(it);
    endtask

    task automatic send_lookup(input logic hit, input logic [SESS_W-1:0] sess);
        seq_item_t it;
        it            = random_item(CMD_LOOKUP_REPLY);
        it.lookup_hit = hit;
        it.session    = sess;
        send_item(it);
    endtask

    task automatic send_status(input logic [CMD_W-1:0] c, input logic [SESS_W-1:0] sess,
                               input logic succ);
        seq_item_t it;
        it         = random_item(c);
        it.session = sess;
        it.success = succ;
        send_item(it);
    endtask

    task automatic send_close(input logic [SESS_W-1:0] sess);
        seq_item_t it;
        it         = random_item(CMD_CLOSE);
        it.session = sess;
        send_item(it);
    endtask

    task automatic send_state(input logic [STATE_W-1:0] st);
        seq_item_t it;
        it       = random_item(CMD_STATE_REPLY);
        it.state = st;
        send_item(it);
    endtask

    // Now and then breaks a sequence with one or two items of any command.
    task automatic maybe_noise();
        if ($urandom_range(99) < 12)
            repeat ($urandom_range(2, 1)) send_item(random_item(CMD_W'($urandom)));
    endtask

    // Waits until every expected result has come and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_local_ip(input logic [IP_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run if no channel moves a transaction for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("No transaction accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned       p;
        int unsigned       start;
        int unsigned       pick;
        bit                hold_sent;
        logic [SESS_W-1:0] sess;
        logic [IP_W-1:0]   ip_value;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_OPEN_REQ;
        remote_ip    = '0;
        remote_port  = '0;
        free_port    = '0;
        lookup_hit   = 1'b0;
        session_in   = '0;
        success_in   = 1'b0;
        state_in     = ST_CLOSED;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        cfg_writes   = 0;
        hold_sent    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dropped items, field extremes and every command.
        set_local_ip(32'h8000_0001);
        send_state(ST_ESTABLISHED);
        send_port_reply(16'h1234);
        send_item(random_item(CMD_UNUSED));
        send_open(32'hFFFF_FFFF, 16'hFFFF);
        send_close(10'd3);
        send_lookup(1'b1, 10'd4);
        send_port_reply(16'h12AB);
        send_open(32'h0000_0000, 16'h0000);
        send_port_reply(16'hFFFF);
        send_open(32'h0102_0304, 16'h8001);
        send_port_reply(16'h0000);
        send_lookup(1'b1, 10'h3FF);
        send_lookup(1'b0, 10'd5);
        send_status(CMD_RX_STATUS, 10'd0, 1'b1);
        send_status(CMD_TIMER_STATUS, 10'h3FF, 1'b0);
        send_close(10'h3FF);
        send_open(32'hDEAD_BEEF, 16'h0050);
        send_state(ST_ESTABLISHED);
        send_close(10'd0);
        send_state(ST_FIN_WAIT_1);
        send_close(10'h200);
        send_state(ST_FIN_WAIT_2);
        send_close(10'd7);
        send_state(ST_CLOSED);
        send_close(10'd9);
        send_state(ST_UNDEFINED);

        // Random sequences, one idling mix and one local address per phase.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: ip_value = 32'h0000_0000;
                2: ip_value = 32'hFFFF_FFFF;
                default: ip_value = $urandom;
            endcase
            set_local_ip(ip_value);
            idle_pct  = (p == 1) ? 52 : (p == 3) ? 24 : 0;
            stall_pct = (p == 2) ? 52 : (p == 3) ? 24 : 0;
            start     = items_with_results;
            while (items_with_results - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    send_open($urandom, PORT_W'($urandom));
                    maybe_noise();
                    send_port_reply(PORT_W'($urandom));
                    maybe_noise();
                    send_lookup($urandom_range(99) < 70, SESS_W'($urandom));
                end
                else if (pick < 70)
                begin
                    sess = SESS_W'($urandom);
                    send_close(sess);
                    maybe_noise();
                    if ($urandom_range(99) < 60)
                        send_state(ST_ESTABLISHED + STATE_W'($urandom_range(2)));
                    else
                        send_state(STATE_W'($urandom));
                end
                else if (pick < 88)
                    send_status(pick < 79 ? CMD_RX_STATUS : CMD_TIMER_STATUS,
                                SESS_W'($urandom), 1'($urandom));
                else
                    send_item(random_item(CMD_W'($urandom)));

                // Long output hold-off while the sender keeps offering.
                if (p == 0 && !hold_sent && items_with_results - start > PHASE_ITEMS / 3)
                begin
                    hold_request = 1'b1;
                    hold_sent    = 1'b1;
                end
            end
        end

        drain();
        $display("Checked %0d results from %0d input transactions, %0d of them with results.",
                 results_checked, items_seen, items_with_results);
        $display("Four idling mixes, one long output hold-off and %0d local address writes.",
                 cfg_writes);
        if (mismatch_count == 0 && pending_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### tcp_active_open_close_sequencer.f
+incdir+rtl
rtl/taocs_pkg.sv
rtl/taocs_front.sv
rtl/taocs_queue.sv
rtl/taocs_back.sv
rtl/tcp_active_open_close_sequencer.sv
tb/seq_result_checker.sv
tb/tb.sv
